>>> hw/rtl/bbcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbcp_pkg: shared types and constants of the Bayer block color pipeline
// Item layouts, register map, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package bbcp_pkg;

  // Fixed field widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned GainW    = 10;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RowW     = 3 * CoefW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = RowW;
  localparam int unsigned GammaDepth = 256;

  // Register reset values
  localparam logic [SampleW-1:0] BlackLevelRst = 8'd16;
  localparam logic [GainW-1:0]   GainRedRst    = 10'd535;
  localparam logic [GainW-1:0]   GainGreenRst  = 10'd256;
  localparam logic [GainW-1:0]   GainBlueRst   = 10'd455;
  // Coefficients from the low slice upward: red, green, blue
  localparam logic [RowW-1:0] RowRedRst   = {16'hFF4A, 16'hFE98, 16'h061E}; // 1566 -360 -182
  localparam logic [RowW-1:0] RowGreenRst = {16'hFE73, 16'h06AF, 16'hFEDE}; // -290 1711 -397
  localparam logic [RowW-1:0] RowBlueRst  = {16'h0638, 16'hFDB6, 16'h0011}; // 17 -586 1592

  typedef enum logic [0:0] {
    OP_PIXEL       = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLACK_LEVEL      = 3'd0,
    CFG_GAIN_RED         = 3'd1,
    CFG_GAIN_GREEN       = 3'd2,
    CFG_GAIN_BLUE        = 3'd3,
    CFG_MATRIX_ROW_RED   = 3'd4,
    CFG_MATRIX_ROW_GREEN = 3'd5,
    CFG_MATRIX_ROW_BLUE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] black_level;
    logic [GainW-1:0]   gain_red;
    logic [GainW-1:0]   gain_green;
    logic [GainW-1:0]   gain_blue;
    logic [RowW-1:0]    matrix_row_red;
    logic [RowW-1:0]    matrix_row_green;
    logic [RowW-1:0]    matrix_row_blue;
  } cfg_t;

  typedef struct packed {
    op_e                opcode;
    logic [SampleW-1:0] blue_sample;
    logic [SampleW-1:0] green_top;
    logic [SampleW-1:0] green_bottom;
    logic [SampleW-1:0] red_sample;
    logic [SampleW-1:0] table_index;
    logic [SampleW-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] red_out;
    logic [SampleW-1:0] green_out;
    logic [SampleW-1:0] blue_out;
  } out_item_t;

  // Classified item between front and back: balanced channels or a table write
  typedef struct packed {
    op_e                opcode;
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
    logic [SampleW-1:0] tbl_index;
    logic [SampleW-1:0] tbl_value;
  } mid_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/bayer_block_color_pipeline_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_block_color_pipeline_top: BGGR block to gamma-encoded RGB
// Pixel path: front, middle queue, product, address, gamma read, result queue.
// Throughput: one item per cycle unless stalled; the nine-product matrix stage
// is pipelined; the gamma table is in three RAM copies, one read port per channel.
// Reset: registers return to their defaults and all queues empty; gamma table
// contents stay undefined until loaded with table-write items.
// ----------------------------------------------------------------------------
module bayer_block_color_pipeline_top
  import bbcp_pkg::*;
#(
  parameter int unsigned MidDepth = 4,
  parameter int unsigned OutDepth = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Input queue side
  input  wire logic                push,
  output logic                     full,
  input  wire in_item_t            in_item_i,
  // Result queue side
  output logic                     empty,
  input  wire logic                pop,
  output out_item_t                out_item_o
);

  localparam int unsigned MidCntW = $clog2(MidDepth + 1);

  cfg_t                cfg_q, cfg_d;
  logic                mid_push, mid_pop, mid_empty, mid_full;
  mid_item_t           mid_in, mid_out;
  logic [MidCntW-1:0]  mid_cnt;

  // Register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_BLACK_LEVEL:      cfg_d.black_level      = cfg_wdata_i[SampleW-1:0];
        CFG_GAIN_RED:         cfg_d.gain_red         = cfg_wdata_i[GainW-1:0];
        CFG_GAIN_GREEN:       cfg_d.gain_green       = cfg_wdata_i[GainW-1:0];
        CFG_GAIN_BLUE:        cfg_d.gain_blue        = cfg_wdata_i[GainW-1:0];
        CFG_MATRIX_ROW_RED:   cfg_d.matrix_row_red   = cfg_wdata_i[RowW-1:0];
        CFG_MATRIX_ROW_GREEN: cfg_d.matrix_row_green = cfg_wdata_i[RowW-1:0];
        CFG_MATRIX_ROW_BLUE:  cfg_d.matrix_row_blue  = cfg_wdata_i[RowW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black_level      <= BlackLevelRst;
      cfg_q.gain_red         <= GainRedRst;
      cfg_q.gain_green       <= GainGreenRst;
      cfg_q.gain_blue        <= GainBlueRst;
      cfg_q.matrix_row_red   <= RowRedRst;
      cfg_q.matrix_row_green <= RowGreenRst;
      cfg_q.matrix_row_blue  <= RowBlueRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and balance
  bbcp_front #(
    .MidDepth (MidDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .mid_cnt_i  (mid_cnt),
    .mid_push_o (mid_push),
    .mid_item_o (mid_in)
  );

  // Queue between front and back
  bbcp_fifo #(
    .Width ($bits(mid_item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o (mid_cnt)
  );

  // Back: matrix, gamma, results
  bbcp_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

  // Front credit must never push into a full middle queue
  a_mid_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("middle queue overflow");

  // A full middle queue must stall the input side
  a_full_when_mid_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_full |-> full)
    else $error("input not stalled on full middle queue");

  // Back only pulls real items
  a_mid_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("middle queue underflow");

endmodule
`default_nettype wire

>>> hw/rtl/bbcp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbcp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/bbcp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbcp_fifo: small register-based queue
// Show-ahead read: the head item is on data_o while empty_o is low.
// ----------------------------------------------------------------------------
module bbcp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o,
  output logic                  full_o,
  output logic      [CntW-1:0]  count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      2'b11:   count_d = count_q;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bbcp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbcp_front: input stage of the color pipeline
// Accepts items, applies black level and white balance to pixel blocks and
// forwards table writes untouched into the middle queue.
// ----------------------------------------------------------------------------
module bbcp_front
  import bbcp_pkg::*;
#(
  parameter int unsigned MidDepth = 4,
  localparam int unsigned MidCntW = $clog2(MidDepth + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item_i,
  input  wire logic [MidCntW-1:0] mid_cnt_i,
  output logic                    mid_push_o,
  output mid_item_t               mid_item_o
);

  logic          valid_q;
  mid_item_t     item_q, item_d;
  logic          accept;
  logic [MidCntW:0] level;
  logic [SampleW:0] green_sum;

  // Pedestal removal, Q8 gain, saturate at 255
  function automatic logic [SampleW-1:0] level_gain(
    input logic [SampleW-1:0] s,
    input logic [SampleW-1:0] bl,
    input logic [GainW-1:0]   gain
  );
    logic [SampleW-1:0]       v;
    logic [SampleW+GainW-1:0] prod;
    v    = (s > bl) ? s - bl : '0;
    prod = (SampleW+GainW)'(v) * (SampleW+GainW)'(gain);
    if (|prod[SampleW+GainW-1:2*SampleW]) begin
      return '1;
    end
    return prod[2*SampleW-1:SampleW];
  endfunction

  // Space check counts the item held in this stage
  assign level  = {1'b0, mid_cnt_i} + {{MidCntW{1'b0}}, valid_q};
  assign full   = (level >= (MidCntW+1)'(MidDepth));
  assign accept = push && !full;

  // Classify and balance
  always_comb begin
    green_sum        = {1'b0, in_item_i.green_top} + {1'b0, in_item_i.green_bottom};
    item_d.opcode    = in_item_i.opcode;
    item_d.red       = level_gain(in_item_i.red_sample, cfg_i.black_level, cfg_i.gain_red);
    item_d.green     = level_gain(green_sum[SampleW:1], cfg_i.black_level, cfg_i.gain_green);
    item_d.blue      = level_gain(in_item_i.blue_sample, cfg_i.black_level, cfg_i.gain_blue);
    item_d.tbl_index = in_item_i.table_index;
    item_d.tbl_value = in_item_i.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign mid_push_o = valid_q;
  assign mid_item_o = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/bbcp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbcp_back: color matrix, gamma lookup and result queue
// Pulls items from the middle queue only when the result queue has room for
// everything in flight; table writes update the gamma RAMs in order.
// ----------------------------------------------------------------------------
module bbcp_back
  import bbcp_pkg::*;
#(
  parameter int unsigned OutDepth = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      mid_empty_i,
  input  wire mid_item_t mid_item_i,
  output logic           mid_pop_o,
  input  wire logic      pop,
  output logic           empty,
  output out_item_t      out_item_o
);

  localparam int unsigned OutCntW = $clog2(OutDepth + 1);
  localparam int unsigned ProdW   = CoefW + SampleW + 1;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned AddrW   = $clog2(GammaDepth);

  // Stage 1: products
  logic                     valid1_q;
  op_e                      op1_q;
  logic [SampleW-1:0]       widx1_q, wval1_q;
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [ProdW-1:0]  prod_d [3][3];
  logic [RowW-1:0]          rows [3];
  logic [SampleW-1:0]       chans [3];

  // Stage 2: gamma addresses
  logic                     valid2_q;
  op_e                      op2_q;
  logic [SampleW-1:0]       widx2_q, wval2_q;
  logic [AddrW-1:0]         addr2_q [3];
  logic [AddrW-1:0]         addr2_d [3];
  logic signed [SumW-1:0]   sum [3];

  // Stage 3: gamma read
  logic                     valid3_q;
  logic [SampleW-1:0]       rdata [3];
  logic                     tbl_we;

  // Result queue and credit
  logic [OutCntW-1:0]       out_cnt;
  logic [OutCntW:0]         committed;
  logic                     out_full;
  out_item_t                out_data;

  assign committed = {1'b0, out_cnt} + {{OutCntW{1'b0}}, valid1_q}
                   + {{OutCntW{1'b0}}, valid2_q} + {{OutCntW{1'b0}}, valid3_q};
  assign mid_pop_o = !mid_empty_i && (committed < (OutCntW+1)'(OutDepth));

  // Nine coefficient products
  always_comb begin
    rows[0]  = cfg_i.matrix_row_red;
    rows[1]  = cfg_i.matrix_row_green;
    rows[2]  = cfg_i.matrix_row_blue;
    chans[0] = mid_item_i.red;
    chans[1] = mid_item_i.green;
    chans[2] = mid_item_i.blue;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = ProdW'($signed(rows[i][CoefW*j +: CoefW]))
                     * ProdW'($signed({1'b0, chans[j]}));
      end
    end
  end

  // Row sums, rounding, clamp to 0..255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SumW'(prod_q[i][0]) + SumW'(prod_q[i][1]) + SumW'(prod_q[i][2])
             + SumW'(512);
      if (sum[i][SumW-1]) begin
        addr2_d[i] = '0;
      end else if (|sum[i][SumW-2:SampleW+10]) begin
        addr2_d[i] = '1;
      end else begin
        addr2_d[i] = sum[i][SampleW+9:10];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= mid_pop_o;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q && (op2_q == OP_PIXEL);
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    op1_q   <= mid_item_i.opcode;
    widx1_q <= mid_item_i.tbl_index;
    wval1_q <= mid_item_i.tbl_value;
    prod_q  <= prod_d;
    op2_q   <= op1_q;
    widx2_q <= widx1_q;
    wval2_q <= wval1_q;
    addr2_q <= addr2_d;
  end

  // Gamma tables: one copy per channel, written together
  assign tbl_we = valid2_q && (op2_q == OP_TABLE_WRITE);

  for (genvar k = 0; k < 3; k++) begin : g_gamma
    bbcp_ram #(
      .Width (SampleW),
      .Depth (GammaDepth)
    ) u_gamma (
      .clk_i   (clk_i),
      .we_i    (tbl_we),
      .waddr_i (widx2_q),
      .wdata_i (wval2_q),
      .raddr_i (addr2_q[k]),
      .rdata_o (rdata[k])
    );
  end

  assign out_data.red_out   = rdata[0];
  assign out_data.green_out = rdata[1];
  assign out_data.blue_out  = rdata[2];

  // Result queue
  bbcp_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (valid3_q),
    .data_i  (out_data),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty),
    .full_o  (out_full),
    .count_o (out_cnt)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule
`default_nettype wire
